// ===== rtl/otsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared constants and controller/datapath interface types for the Otsu
// threshold block.
// ----------------------------------------------------------------------------
package otsu_pkg;

	localparam int COUNT_BITS = 24;
	localparam int NUM_BINS   = 256;
	localparam int BIN_BITS   = 8;
	localparam int QBITS      = 8;

	typedef struct packed {
		logic use_pix;
		logic accept;
		logic pix_wr;
		logic scan_init;
		logic acc_total;
		logic acc_below;
		logic inc_idx;
		logic div_init;
		logic div_step;
		logic mul1;
		logic mul2;
		logic cmp;
		logic finish;
	} otsu_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic last;
		logic skip;
		logic div_last;
	} otsu_stat_t;

endpackage

// ===== rtl/otsu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_ctrl
// Sequencer: histogram update per pixel, then total-sum pass and scoring pass.
// ----------------------------------------------------------------------------
module otsu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  otsu_pkg::otsu_stat_t stat,
	output otsu_pkg::otsu_cmd_t  cmd
);

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_PIX_WR = 12'b0000_0000_0010,
		ST_S1_RD  = 12'b0000_0000_0100,
		ST_S1_ACC = 12'b0000_0000_1000,
		ST_S2_RD  = 12'b0000_0001_0000,
		ST_S2_ACC = 12'b0000_0010_0000,
		ST_S2_CHK = 12'b0000_0100_0000,
		ST_DIV    = 12'b0000_1000_0000,
		ST_MUL1   = 12'b0001_0000_0000,
		ST_MUL2   = 12'b0010_0000_0000,
		ST_CMP    = 12'b0100_0000_0000,
		ST_DONE   = 12'b1000_0000_0000
	} otsu_state_t;

	otsu_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.use_pix = 1'b1;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = ST_PIX_WR;
				end
			end
			ST_PIX_WR: begin
				cmd.pix_wr = 1'b1;
				if (stat.last) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_S1_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_S1_RD: state_d = ST_S1_ACC;
			ST_S1_ACC: begin
				cmd.acc_total = 1'b1;
				cmd.inc_idx   = 1'b1;
				state_d       = stat.idx_last ? ST_S2_RD : ST_S1_RD;
			end
			ST_S2_RD: state_d = ST_S2_ACC;
			ST_S2_ACC: begin
				cmd.acc_below = 1'b1;
				state_d       = ST_S2_CHK;
			end
			ST_S2_CHK: begin
				if (stat.skip) begin
					cmd.inc_idx = 1'b1;
					state_d     = stat.idx_last ? ST_DONE : ST_S2_RD;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp     = 1'b1;
				cmd.inc_idx = 1'b1;
				state_d     = stat.idx_last ? ST_DONE : ST_S2_RD;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/otsu_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_dpath
// Histogram memory, accumulators, dual bit-serial divider, score multiply
// and best-score tracking.
// ----------------------------------------------------------------------------
module otsu_dpath #(
	parameter int COUNT_BITS = otsu_pkg::COUNT_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [otsu_pkg::BIN_BITS-1:0]         pixel,
	input  logic                                 last_pixel,
	input  otsu_pkg::otsu_cmd_t                   cmd,
	output otsu_pkg::otsu_stat_t                  stat,
	output logic                                 done,
	output logic [otsu_pkg::BIN_BITS-1:0]         threshold,
	output logic                                 frame_overflow
);

	localparam int CW  = COUNT_BITS + 1;
	localparam int SW  = COUNT_BITS + 8;
	localparam int PW  = 2 * CW;
	localparam int SCW = PW + 2 * otsu_pkg::QBITS;
	localparam int BB  = otsu_pkg::BIN_BITS;
	localparam int QB  = otsu_pkg::QBITS;

	logic [CW-1:0]         mem [otsu_pkg::NUM_BINS];
	logic [otsu_pkg::NUM_BINS-1:0] valid_q;
	logic [CW-1:0]         rd_q;
	logic                  rd_vld_q;
	logic [BB-1:0]         rd_addr;
	logic [CW-1:0]         cnt;

	logic [BB-1:0]         pix_q;
	logic                  last_q;
	logic [CW-1:0]         total_q;
	logic                  ovf_q;
	logic [BB-1:0]         idx_q;
	logic [SW-1:0]         tsum_q;
	logic [CW-1:0]         bcnt_q;
	logic [SW-1:0]         bsum_q;
	logic [CW-1:0]         above;
	logic [CW+7:0]         wprod;

	logic [SW-1:0]         rem_lo_q, rem_hi_q, dsh_lo_q, dsh_hi_q;
	logic [QB-1:0]         q_lo_q, q_hi_q;
	logic [2:0]            step_q;
	logic [QB-1:0]         diff;

	logic [PW-1:0]         prod_q;
	logic [2*QB-1:0]       dsq_q;
	logic [SCW-1:0]        score_q;
	logic [SCW-1:0]        best_q;
	logic [BB-1:0]         best_bin_q;

	logic                  done_q;
	logic [BB-1:0]         thr_q;
	logic                  fovf_q;

	assign rd_addr = cmd.use_pix ? pixel : idx_q;
	assign cnt     = rd_vld_q ? rd_q : '0;
	assign wprod   = (CW+8)'(idx_q) * (CW+8)'(cnt);
	assign above   = total_q - bcnt_q;
	assign diff    = (q_lo_q > q_hi_q) ? (q_lo_q - q_hi_q) : (q_hi_q - q_lo_q);

	assign stat.idx_last = (idx_q == BB'(otsu_pkg::NUM_BINS - 1));
	assign stat.last     = last_q;
	assign stat.skip     = (bcnt_q == '0) || (above == '0);
	assign stat.div_last = (step_q == 3'd0);

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (cmd.pix_wr && !total_q[CW-1]) begin
			mem[pix_q] <= cnt + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
			total_q  <= '0;
			ovf_q    <= 1'b0;
			idx_q    <= '0;
			last_q   <= 1'b0;
			done_q   <= 1'b0;
			best_q   <= '0;
			best_bin_q <= '0;
		end else begin
			rd_vld_q <= valid_q[rd_addr];
			done_q   <= cmd.finish;
			if (cmd.accept) begin
				last_q <= last_pixel;
			end
			if (cmd.pix_wr) begin
				if (!total_q[CW-1]) begin
					valid_q[pix_q] <= 1'b1;
					total_q        <= total_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.inc_idx) begin
				idx_q <= idx_q + BB'(1);
			end
			if (cmd.cmp && (score_q > best_q)) begin
				best_q     <= score_q;
				best_bin_q <= idx_q;
			end
			if (cmd.finish) begin
				valid_q    <= '0;
				total_q    <= '0;
				ovf_q      <= 1'b0;
				best_q     <= '0;
				best_bin_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q <= pixel;
		end
		if (cmd.scan_init) begin
			tsum_q <= '0;
			bcnt_q <= '0;
			bsum_q <= '0;
		end
		if (cmd.acc_total) begin
			tsum_q <= tsum_q + wprod[SW-1:0];
		end
		if (cmd.acc_below) begin
			bcnt_q <= bcnt_q + cnt;
			bsum_q <= bsum_q + wprod[SW-1:0];
		end
		if (cmd.div_init) begin
			rem_lo_q <= bsum_q;
			rem_hi_q <= tsum_q - bsum_q;
			dsh_lo_q <= {bcnt_q, 7'b0};
			dsh_hi_q <= {above, 7'b0};
			q_lo_q   <= '0;
			q_hi_q   <= '0;
			step_q   <= 3'd7;
		end
		if (cmd.div_step) begin
			if (rem_lo_q >= dsh_lo_q) begin
				rem_lo_q <= rem_lo_q - dsh_lo_q;
				q_lo_q   <= {q_lo_q[QB-2:0], 1'b1};
			end else begin
				q_lo_q <= {q_lo_q[QB-2:0], 1'b0};
			end
			if (rem_hi_q >= dsh_hi_q) begin
				rem_hi_q <= rem_hi_q - dsh_hi_q;
				q_hi_q   <= {q_hi_q[QB-2:0], 1'b1};
			end else begin
				q_hi_q <= {q_hi_q[QB-2:0], 1'b0};
			end
			dsh_lo_q <= dsh_lo_q >> 1;
			dsh_hi_q <= dsh_hi_q >> 1;
			step_q   <= step_q - 3'd1;
		end
		if (cmd.mul1) begin
			prod_q <= PW'(bcnt_q) * PW'(above);
			dsq_q  <= (2*QB)'(diff) * (2*QB)'(diff);
		end
		if (cmd.mul2) begin
			score_q <= SCW'(prod_q) * SCW'(dsq_q);
		end
		if (cmd.finish) begin
			thr_q  <= best_bin_q;
			fovf_q <= ovf_q;
		end
	end

	assign done           = done_q;
	assign threshold      = thr_q;
	assign frame_overflow = fovf_q;

endmodule

// ===== rtl/otsu_threshold_from_histogram.sv =====
`timescale 1ns / 1ps
// A pixel is read from the histogram memory, then its count is written back; a new pixel
// is not accepted until the write-back is done. On the last pixel, the write-back is followed
// by the total-sum pass (read, then accumulate, per bin), the scoring pass (read, accumulate
// and check per bin; a scored bin adds the bit-serial divide, two multiplies and the compare)
// and a finish state; done strobes the cycle after that. Reset clears control, histogram
// valid bits and counters at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// otsu_threshold_from_histogram
// Streams grey pixels into a histogram and returns the Otsu threshold per frame.
// ----------------------------------------------------------------------------
module otsu_threshold_from_histogram #(
	parameter int COUNT_BITS = otsu_pkg::COUNT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [otsu_pkg::BIN_BITS-1:0] pixel,
	input  logic                          last_pixel,
	output logic                          done,
	output logic [otsu_pkg::BIN_BITS-1:0] threshold,
	output logic                          frame_overflow
);

	otsu_pkg::otsu_cmd_t  cmd;
	otsu_pkg::otsu_stat_t stat;

	otsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	otsu_dpath #(
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.pixel          (pixel),
		.last_pixel     (last_pixel),
		.cmd            (cmd),
		.stat           (stat),
		.done           (done),
		.threshold      (threshold),
		.frame_overflow (frame_overflow)
	);

endmodule

// ===== rtl/otsu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_checker
// Port-level checks on the command handshake and result strobe.
// ----------------------------------------------------------------------------
module otsu_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_pixel,
	input logic done
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after accept");

	a_pixel_two: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_pixel |=> ##1 !busy)
		else $error("non-last word took more than two cycles");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy)) else $error("done strobe outside scan end");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

endmodule

bind otsu_threshold_from_histogram otsu_checker u_otsu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.last_pixel (last_pixel),
	.done       (done)
);
